FILE: sv/mfrle_pkg.sv
// ----------------------------------------------------------------------------
// mfrle_pkg
// Types and constants shared by the run-length byte decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mfrle_pkg;

  // width of the output word in byte lanes and of the lane count field
  localparam int unsigned WORD_LANES  = 8;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  // stream constants
  localparam logic [7:0] ESC_BYTE  = 8'hff;
  localparam logic [7:0] LIT_FLAG  = 8'h80;
  localparam logic [7:0] LOW7_MASK = 8'h7f;

  // decode format register codes
  typedef enum logic [1:0] {
    FMT_COPY       = 2'd0,
    FMT_ESC_EXACT  = 2'd1,
    FMT_ESC_MINUS1 = 2'd2,
    FMT_CONTROL    = 2'd3
  } fmt_t;

  // parser phases
  typedef enum logic [2:0] {
    PH_START     = 3'd0,
    PH_ESC_COUNT = 3'd1,
    PH_ESC_VALUE = 3'd2,
    PH_CONTROL   = 3'd3,
    PH_LITERAL   = 3'd4,
    PH_REPEAT    = 3'd5,
    PH_DONE      = 3'd6
  } phase_t;

  // input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [63:0]        out_bytes;
    logic [COUNT_W-1:0] byte_count;
    logic               run_end;
  } out_beat_t;

  // fill command between parser and emitter
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] count;
  } fill_cmd_t;

endpackage

`default_nettype wire

FILE: sv/mfrle_front.sv
// ----------------------------------------------------------------------------
// mfrle_front
// Format register and stream parser: turns each input beat into at most one
// fill command (value and copy count) for the emitter queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrle_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  format_we,
  input  wire logic [1:0]            format_wdata,
  input  wire mfrle_pkg::in_beat_t   item,
  input  wire logic                  take,
  output mfrle_pkg::fill_cmd_t       cmd,
  output logic                       push
);

  mfrle_pkg::fmt_t   format;
  mfrle_pkg::phase_t phase, phase_next;
  logic [2:0]        hdr_seen, hdr_seen_next;
  logic [7:0]        pending, pending_next;
  logic [31:0]       remaining, remaining_next;

  mfrle_pkg::phase_t eff_phase;
  logic [2:0]        eff_hdr;
  logic [7:0]        eff_pend;
  logic [31:0]       eff_rem;
  logic [7:0]        b;
  logic [7:0]        esc_n;
  logic [7:0]        lim_n;
  logic [7:0]        cut;
  logic [31:0]       rem_after;
  logic [31:0]       hdr_acc;
  logic [7:0]        pend_dec;
  logic              want_push;

  // a stream start clears the parser before this byte is used
  assign b         = item.data_byte;
  assign eff_phase = item.stream_start ? mfrle_pkg::PH_START : phase;
  assign eff_hdr   = item.stream_start ? 3'd0 : hdr_seen;
  assign eff_pend  = item.stream_start ? 8'd0 : pending;
  assign eff_rem   = item.stream_start ? 32'd0 : remaining;

  // escape run length, minus one saturating at zero in that format
  assign esc_n = (format == mfrle_pkg::FMT_ESC_MINUS1 && eff_pend != 8'd0) ?
                 eff_pend - 8'd1 : eff_pend;

  // size-limited copy count for literal and repeat records
  assign pend_dec  = eff_pend - 8'd1;
  assign lim_n     = (eff_phase == mfrle_pkg::PH_LITERAL) ? 8'd1 : eff_pend;
  assign cut       = (eff_rem < {24'd0, lim_n}) ? eff_rem[7:0] : lim_n;
  assign rem_after = eff_rem - {24'd0, cut};

  // little-endian size header accumulation
  assign hdr_acc = eff_rem | ({24'd0, b} << {eff_hdr[1:0], 3'b000});

  // command output
  always_comb begin
    want_push = 1'b0;
    cmd.value = b;
    cmd.count = 8'd0;
    unique case (format)
      mfrle_pkg::FMT_COPY: begin
        want_push = 1'b1;
        cmd.count = 8'd1;
      end
      mfrle_pkg::FMT_ESC_EXACT, mfrle_pkg::FMT_ESC_MINUS1: begin
        if (eff_phase == mfrle_pkg::PH_ESC_VALUE) begin
          cmd.count = esc_n;
          want_push = (esc_n != 8'd0);
        end else if (eff_phase != mfrle_pkg::PH_ESC_COUNT && b != mfrle_pkg::ESC_BYTE) begin
          cmd.count = 8'd1;
          want_push = 1'b1;
        end
      end
      mfrle_pkg::FMT_CONTROL: begin
        if (eff_phase == mfrle_pkg::PH_LITERAL || eff_phase == mfrle_pkg::PH_REPEAT) begin
          cmd.count = cut;
          want_push = (cut != 8'd0);
        end
      end
      default: ;
    endcase
  end

  assign push = take && want_push;

  // parser next state
  always_comb begin
    phase_next     = eff_phase;
    hdr_seen_next  = eff_hdr;
    pending_next   = eff_pend;
    remaining_next = eff_rem;
    unique case (format)
      mfrle_pkg::FMT_COPY: ;
      mfrle_pkg::FMT_ESC_EXACT, mfrle_pkg::FMT_ESC_MINUS1: begin
        if (eff_phase == mfrle_pkg::PH_ESC_COUNT) begin
          pending_next = b;
          phase_next   = mfrle_pkg::PH_ESC_VALUE;
        end else if (eff_phase == mfrle_pkg::PH_ESC_VALUE) begin
          pending_next = 8'd0;
          phase_next   = mfrle_pkg::PH_START;
        end else begin
          phase_next = (b == mfrle_pkg::ESC_BYTE) ? mfrle_pkg::PH_ESC_COUNT :
                       mfrle_pkg::PH_START;
        end
      end
      mfrle_pkg::FMT_CONTROL: begin
        unique case (eff_phase)
          mfrle_pkg::PH_START: begin
            remaining_next = hdr_acc;
            hdr_seen_next  = eff_hdr + 3'd1;
            if (eff_hdr[1:0] == 2'd3) begin
              phase_next = (hdr_acc == 32'd0) ? mfrle_pkg::PH_DONE : mfrle_pkg::PH_CONTROL;
            end
          end
          mfrle_pkg::PH_CONTROL: begin
            if ((b & mfrle_pkg::LIT_FLAG) != 8'd0) begin
              pending_next = (b & mfrle_pkg::LOW7_MASK) + 8'd1;
              phase_next   = mfrle_pkg::PH_LITERAL;
            end else begin
              pending_next = (b & mfrle_pkg::LOW7_MASK) + 8'd3;
              phase_next   = mfrle_pkg::PH_REPEAT;
            end
          end
          mfrle_pkg::PH_LITERAL: begin
            pending_next   = pend_dec;
            remaining_next = rem_after;
            if (rem_after == 32'd0) begin
              phase_next = mfrle_pkg::PH_DONE;
            end else if (pend_dec == 8'd0) begin
              phase_next = mfrle_pkg::PH_CONTROL;
            end
          end
          mfrle_pkg::PH_REPEAT: begin
            pending_next   = 8'd0;
            remaining_next = rem_after;
            phase_next     = (rem_after == 32'd0) ? mfrle_pkg::PH_DONE :
                             mfrle_pkg::PH_CONTROL;
          end
          default: begin
            phase_next = mfrle_pkg::PH_DONE;
          end
        endcase
      end
      default: ;
    endcase
  end

  // format register and parser state; a format write clears the parser
  always_ff @(posedge clk) begin
    if (rst) begin
      format    <= mfrle_pkg::FMT_COPY;
      phase     <= mfrle_pkg::PH_START;
      hdr_seen  <= 3'd0;
      pending   <= 8'd0;
      remaining <= 32'd0;
    end else if (format_we) begin
      format    <= mfrle_pkg::fmt_t'(format_wdata);
      phase     <= mfrle_pkg::PH_START;
      hdr_seen  <= 3'd0;
      pending   <= 8'd0;
      remaining <= 32'd0;
    end else if (take) begin
      phase     <= phase_next;
      hdr_seen  <= hdr_seen_next;
      pending   <= pending_next;
      remaining <= remaining_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mfrle_queue.sv
// ----------------------------------------------------------------------------
// mfrle_queue
// Short command queue between the parser and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrle_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire mfrle_pkg::fill_cmd_t  wr_cmd,
  output logic                       has_room,
  input  wire logic                  pop,
  output mfrle_pkg::fill_cmd_t       head,
  output logic                       head_valid
);

  localparam int unsigned PTR_W = $clog2(mfrle_pkg::QUEUE_DEPTH);

  mfrle_pkg::fill_cmd_t entries [mfrle_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W:0]       fill;

  assign has_room   = (fill != (PTR_W+1)'(mfrle_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/mfrle_back.sv
// ----------------------------------------------------------------------------
// mfrle_back
// Emitter: expands the queue head into packed words of up to OUT_LANES
// copies into a registered output beat, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrle_back #(
  parameter int unsigned OUT_LANES = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mfrle_pkg::fill_cmd_t  head,
  input  wire logic                  head_valid,
  output logic                       pop,
  output mfrle_pkg::out_beat_t       result,
  output logic                       result_valid,
  input  wire logic                  result_ready
);

  logic       busy;
  logic [7:0] left;
  logic [7:0] src;
  logic [7:0] lanes;
  logic [7:0] rest;
  logic       free;
  logic       fire;
  logic [63:0] word;

  // remaining copies of the head command
  assign src   = busy ? left : head.count;
  assign lanes = (src < 8'(OUT_LANES)) ? src : 8'(OUT_LANES);
  assign rest  = src - lanes;
  assign free  = !result_valid || result_ready;
  assign fire  = free && head_valid;
  assign pop   = fire && (rest == 8'd0);

  // replicate the value over the valid lanes
  always_comb begin
    word = '0;
    for (int i = 0; i < mfrle_pkg::WORD_LANES; i++) begin
      word[8*i +: 8] = (4'(i) < lanes[3:0]) ? head.value : 8'h00;
    end
  end

  // run progress
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      left <= 8'd0;
    end else if (fire) begin
      busy <= (rest != 8'd0);
      left <= rest;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.out_bytes  <= word;
      result.byte_count <= lanes[mfrle_pkg::COUNT_W-1:0];
      result.run_end    <= (rest == 8'd0);
    end
  end

endmodule

`default_nettype wire

FILE: sv/multi_format_rle_byte_decoder.sv
// ----------------------------------------------------------------------------
// multi_format_rle_byte_decoder
// Run-length byte decoder for copy, escape and control-byte formats.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) takes one compressed byte per
//   beat with a stream_start flag that clears the parser first.
//   result channel (result_valid/result_ready/result) gives packed words of
//   up to OUT_LANES copies of one byte; run_end marks the last word caused by
//   an input byte. Bytes that produce nothing give no result beat.
//   format_we/format_wdata write the format register and clear the parser;
//   write it only while the block is idle.
//   The first word of an input byte passes the command queue, then the
//   output register. The parser takes one byte per cycle while the
//   two-entry command queue has room; the emitter drains one word per
//   cycle while the output is free, so a run of n bytes takes
//   ceil(n / OUT_LANES) words and long runs back up the queue and stall
//   the input.
//   Reset: format is plain copy, the parser is cleared, queue and output
//   register are empty. When result_ready is low a valid output beat holds and
//   the emitter waits; the parser keeps filling the queue until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_format_rle_byte_decoder #(
  parameter int unsigned OUT_LANES = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  format_we,
  input  wire logic [1:0]            format_wdata,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire mfrle_pkg::in_beat_t   item,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output mfrle_pkg::out_beat_t       result
);

  mfrle_pkg::fill_cmd_t cmd;
  mfrle_pkg::fill_cmd_t head;
  logic                 push;
  logic                 pop;
  logic                 has_room;
  logic                 head_valid;
  logic                 take;

  assign item_ready = has_room;
  assign take       = item_valid && has_room;

  // parser
  mfrle_front u_front (
    .clk          (clk),
    .rst          (rst),
    .format_we    (format_we),
    .format_wdata (format_wdata),
    .item         (item),
    .take         (take),
    .cmd          (cmd),
    .push         (push)
  );

  // command queue
  mfrle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_cmd     (cmd),
    .has_room   (has_room),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // emitter
  mfrle_back #(
    .OUT_LANES (OUT_LANES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

`default_nettype wire

FILE: sv/mfrle_checker.sv
// ----------------------------------------------------------------------------
// mfrle_checker
// Port-level checks on the decoder output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrle_checker #(
  parameter int unsigned OUT_LANES = 8
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  result_valid,
  input wire logic                  result_ready,
  input wire mfrle_pkg::out_beat_t  result
);

  // stalled output beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  // no output beat right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // lane count in range
  a_count: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.byte_count != 4'd0) &&
                     (result.byte_count <= 4'(OUT_LANES)))
    else $error("byte_count out of range");

  // lanes above the count are zero
  a_zero_lanes: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.out_bytes >> {result.byte_count, 3'b000}) == 64'd0)
    else $error("unused lanes not zero");

  // only the last word of a run may be partial
  a_full_word: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.run_end |-> result.byte_count == 4'(OUT_LANES))
    else $error("partial word before end of run");

endmodule

bind multi_format_rle_byte_decoder mfrle_checker #(
  .OUT_LANES (OUT_LANES)
) u_mfrle_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire
